// ===== rtl/core/rpa_pkg.sv =====
`timescale 1ns / 1ps

package rpa_pkg;

    // Request codes.
    localparam logic [2:0] ACT_ALLOC  = 3'd0;
    localparam logic [2:0] ACT_FREE   = 3'd1;
    localparam logic [2:0] ACT_ADDREF = 3'd2;
    localparam logic [2:0] ACT_SALLOC = 3'd3;
    localparam logic [2:0] ACT_SFREE  = 3'd4;

    // Status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_NONE  = 3'd1;
    localparam logic [2:0] ST_BAD   = 3'd2;
    localparam logic [2:0] ST_UNREF = 3'd3;
    localparam logic [2:0] ST_OVF   = 3'd4;

    localparam logic [15:0] REF_MAX     = 16'hFFFF;
    localparam logic [5:0]  BATCH_MAX   = 6'd32;
    localparam logic [5:0]  BATCH_RESET = 6'd32;
    localparam logic [1:0]  ADDR_BATCH  = 2'd0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_POP,
        S_FREE,
        S_ADDREF,
        S_SCAN,
        S_WALK
    } state_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLR,
        OP_LATCH,
        OP_POP_RD,
        OP_POP,
        OP_REF_RD,
        OP_FREE,
        OP_ADDREF,
        OP_SCAN_START,
        OP_SCAN_NEXT,
        OP_STEAL_START,
        OP_WALK,
        OP_STEAL_END,
        OP_SUP_ALLOC,
        OP_SUP_FREE,
        OP_SUP_ADDREF,
        OP_BAD,
        OP_NOFREE
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic [2:0] act;
        logic       own_nz;
        logic       pn_small;
        logic       sup_hit;
        logic       scan_nz;
        logic       scan_end;
        logic       walk_last;
        logic       clr_last;
    } stat_t;

endpackage

// ===== rtl/core/refcounted_page_allocator.sv =====
`timescale 1ns / 1ps
// Reference-counted page allocator with per-CPU free lists.
// Request channel: drive action, cpu and page_number with start; the word is
// taken at a rising edge where start is high and busy is low. busy stays high
// until the result is out, so one request is in flight at a time.
// Result channel: done is high for exactly one cycle with status,
// granted_page, ref_count and released; the receiver cannot stall it, and
// busy is already low in that cycle so the next request may be issued.
// Superpage requests and rejected requests finish from the dispatch step. A
// pop from the requester's own list and a small-page free or add-reference
// take one registered memory read then a write. A steal passes over the
// empty lists of the other CPUs in turn, then walks n (1 to 32) pages on the
// victim's list, one link memory read per page. An allocation that finds
// every list empty reports no page.
// Configuration: one APB register, the steal batch size, at byte address 0.
// Reset: after rst_n releases, a sweep over all PAGE_COUNT entries initializes the
// link and count memories; busy is high through it. Configuration writes are
// taken at any time.
module refcounted_page_allocator #(
    parameter int PAGE_COUNT  = 1024,
    parameter int CPU_COUNT   = 8,
    parameter int SUPER_COUNT = 4,
    parameter int SUPER_RATIO = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [2:0]  cpu,
    input  logic [11:0] page_number,
    output logic        done,
    output logic [2:0]  status,
    output logic [11:0] granted_page,
    output logic [15:0] ref_count,
    output logic        released,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rpa_pkg::*;

    logic [5:0] batch_reg;
    cmd_t       cmd;
    stat_t      stat;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_reg <= BATCH_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_BATCH)
        begin
            batch_reg <= pwdata[5:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BATCH) ? {26'd0, batch_reg} : 32'd0;

    rpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    rpa_dp #(
        .PAGE_COUNT  (PAGE_COUNT),
        .CPU_COUNT   (CPU_COUNT),
        .SUPER_COUNT (SUPER_COUNT),
        .SUPER_RATIO (SUPER_RATIO)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .action       (action),
        .cpu          (cpu),
        .page_number  (page_number),
        .batch        (batch_reg),
        .stat         (stat),
        .done         (done),
        .status       (status),
        .granted_page (granted_page),
        .ref_count    (ref_count),
        .released     (released)
    );

endmodule

// ===== rtl/core/rpa_ctrl.sv =====
`timescale 1ns / 1ps

module rpa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  rpa_pkg::stat_t stat,
    output rpa_pkg::cmd_t  cmd,
    output logic           busy
);
    import rpa_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register; the page memories are swept right after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.act)
                    ACT_ALLOC:  state_next = stat.own_nz ? S_POP : S_SCAN;
                    ACT_FREE:   state_next = stat.pn_small ? S_FREE : S_IDLE;
                    ACT_ADDREF: state_next = stat.pn_small ? S_ADDREF : S_IDLE;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_SCAN:
            begin
                if (stat.scan_end)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.scan_nz)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (stat.walk_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_POP, S_FREE, S_ADDREF:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd.op = OP_NOP;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLR;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.act)
                    ACT_ALLOC:  cmd.op = stat.own_nz ? OP_POP_RD : OP_SCAN_START;
                    ACT_FREE:   cmd.op = stat.pn_small ? OP_REF_RD : OP_BAD;
                    ACT_ADDREF:
                    begin
                        if (stat.pn_small)
                        begin
                            cmd.op = OP_REF_RD;
                        end
                        else
                        begin
                            cmd.op = stat.sup_hit ? OP_SUP_ADDREF : OP_BAD;
                        end
                    end
                    ACT_SALLOC: cmd.op = OP_SUP_ALLOC;
                    ACT_SFREE:  cmd.op = stat.sup_hit ? OP_SUP_FREE : OP_BAD;
                    default:    cmd.op = OP_BAD;
                endcase
            end
            S_POP:
            begin
                cmd.op = OP_POP;
            end
            S_FREE:
            begin
                cmd.op = OP_FREE;
            end
            S_ADDREF:
            begin
                cmd.op = OP_ADDREF;
            end
            S_SCAN:
            begin
                if (stat.scan_end)
                begin
                    cmd.op = OP_NOFREE;
                end
                else if (stat.scan_nz)
                begin
                    cmd.op = OP_STEAL_START;
                end
                else
                begin
                    cmd.op = OP_SCAN_NEXT;
                end
            end
            S_WALK:
            begin
                cmd.op = stat.walk_last ? OP_STEAL_END : OP_WALK;
            end
            default:
            begin
                cmd.op = OP_NOP;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/core/rpa_dp.sv =====
`timescale 1ns / 1ps

module rpa_dp #(
    parameter int PAGE_COUNT  = 1024,
    parameter int CPU_COUNT   = 8,
    parameter int SUPER_COUNT = 4,
    parameter int SUPER_RATIO = 512
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rpa_pkg::cmd_t  cmd,
    input  logic [2:0]     action,
    input  logic [2:0]     cpu,
    input  logic [11:0]    page_number,
    input  logic [5:0]     batch,
    output rpa_pkg::stat_t stat,
    output logic           done,
    output logic [2:0]     status,
    output logic [11:0]    granted_page,
    output logic [15:0]    ref_count,
    output logic           released
);
    import rpa_pkg::*;

    localparam int PW  = $clog2(PAGE_COUNT);
    localparam int LW  = $clog2(PAGE_COUNT + 1);
    localparam int CW  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int IW  = $clog2(CPU_COUNT + 1);
    localparam int SC1 = (SUPER_COUNT > 0) ? SUPER_COUNT : 1;
    localparam int SW  = (SC1 > 1) ? $clog2(SC1) : 1;
    localparam int SLW = (SUPER_COUNT > 0) ? $clog2(SUPER_COUNT + 1) : 1;

    // Request, reduced to the CPU range by repeated subtraction.
    function automatic logic [CW-1:0] cpu_mod(input logic [2:0] c);
        logic [6:0] v;
        v = {4'd0, c};
        for (int i = 0; i < 8; i++)
        begin
            if (v >= 7'(CPU_COUNT))
            begin
                v = v - 7'(CPU_COUNT);
            end
        end
        return v[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] cpu_inc(input logic [CW-1:0] c);
        logic [CW:0] t;
        t = {1'b0, c} + 1'b1;
        return (t == (CW+1)'(CPU_COUNT)) ? '0 : t[CW-1:0];
    endfunction

    // Page link and reference count memories.
    logic [PW-1:0] link_mem [PAGE_COUNT];
    logic [15:0]   refs_mem [PAGE_COUNT];
    logic [PW-1:0] link_rd_reg;
    logic [15:0]   refs_rd_reg;
    logic          link_we, refs_we;
    logic [PW-1:0] link_waddr, link_wdata, link_raddr, refs_waddr, refs_raddr;
    logic [15:0]   refs_wdata;

    // Per-CPU list heads and lengths.
    logic [PW-1:0] head_reg [CPU_COUNT];
    logic [LW-1:0] len_reg  [CPU_COUNT];

    // Superpage list.
    logic [SW-1:0]  sup_link_reg [SC1];
    logic [15:0]    sup_refs_reg [SC1];
    logic [SW-1:0]  sup_head_reg;
    logic [SLW-1:0] sup_len_reg;

    // Request and walk registers.
    logic [2:0]    act_reg;
    logic [CW-1:0] cpu_reg, src_reg;
    logic [11:0]   pn_reg;
    logic          steal_reg;
    logic [IW-1:0] scan_i_reg;
    logic [5:0]    n_reg, k_reg;
    logic [PW-1:0] first_reg, second_reg;
    logic [PW-1:0] clr_cnt_reg;

    // Result registers.
    logic        done_reg, rel_reg;
    logic [2:0]  status_reg;
    logic [11:0] granted_reg;
    logic [15:0] refc_reg;

    logic          res_v, res_rel;
    logic [2:0]    res_st;
    logic [11:0]   res_gp;
    logic [15:0]   res_rc;

    logic [CW-1:0]    lidx;
    logic [PW-1:0]    cur_head;
    logic [LW-1:0]    cur_len;
    logic [PW+11:0]   pn_ext;
    logic [PW-1:0]    pn_idx;
    logic             pn_small;
    logic             sup_hit;
    logic [SW-1:0]    sup_idx;
    logic [15:0]      sup_r;
    logic [5:0]       batch_eff;
    logic [5:0]       n_take;

    // List selection: the victim list during a steal, else the requester's.
    assign lidx     = steal_reg ? src_reg : cpu_reg;
    assign cur_head = head_reg[lidx];
    assign cur_len  = len_reg[lidx];
    assign pn_ext   = {{PW{1'b0}}, pn_reg};
    assign pn_idx   = pn_ext[PW-1:0];
    assign pn_small = 32'(pn_reg) < 32'(PAGE_COUNT);
    assign sup_r    = sup_refs_reg[sup_idx];

    // Superpage frame decode: match against each superpage's first frame.
    always_comb
    begin
        sup_hit = 1'b0;
        sup_idx = '0;
        for (int s = 0; s < SUPER_COUNT; s++)
        begin
            if (32'(pn_reg) == 32'(PAGE_COUNT + s * SUPER_RATIO))
            begin
                sup_hit = 1'b1;
                sup_idx = SW'(s);
            end
        end
    end

    // Effective steal size.
    always_comb
    begin
        if (batch == 6'd0)
        begin
            batch_eff = 6'd1;
        end
        else if (batch > BATCH_MAX)
        begin
            batch_eff = BATCH_MAX;
        end
        else
        begin
            batch_eff = batch;
        end
        n_take = (32'(cur_len) < 32'(batch_eff)) ? 6'(cur_len) : batch_eff;
    end

    assign stat.act       = act_reg;
    assign stat.own_nz    = (cur_len != '0);
    assign stat.pn_small  = pn_small;
    assign stat.sup_hit   = sup_hit;
    assign stat.scan_nz   = (cur_len != '0);
    assign stat.scan_end  = (scan_i_reg == IW'(CPU_COUNT));
    assign stat.walk_last = (k_reg == n_reg);
    assign stat.clr_last  = (clr_cnt_reg == PW'(PAGE_COUNT - 1));

    // Memory port control.
    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        link_raddr = '0;
        refs_we    = 1'b0;
        refs_waddr = '0;
        refs_wdata = '0;
        refs_raddr = '0;
        case (cmd.op)
            OP_CLR:
            begin
                link_we    = 1'b1;
                link_waddr = clr_cnt_reg;
                link_wdata = (clr_cnt_reg == '0) ? '0 : clr_cnt_reg - 1'b1;
                refs_we    = 1'b1;
                refs_waddr = clr_cnt_reg;
            end
            OP_POP_RD, OP_STEAL_START:
            begin
                link_raddr = cur_head;
            end
            OP_WALK:
            begin
                link_raddr = link_rd_reg;
            end
            OP_POP:
            begin
                refs_we    = 1'b1;
                refs_waddr = cur_head;
                refs_wdata = 16'd1;
            end
            OP_REF_RD:
            begin
                refs_raddr = pn_idx;
            end
            OP_FREE:
            begin
                if (refs_rd_reg != 16'd0)
                begin
                    refs_we    = 1'b1;
                    refs_waddr = pn_idx;
                    refs_wdata = refs_rd_reg - 16'd1;
                end
                if (refs_rd_reg == 16'd1)
                begin
                    link_we    = 1'b1;
                    link_waddr = pn_idx;
                    link_wdata = cur_head;
                end
            end
            OP_ADDREF:
            begin
                if (refs_rd_reg != 16'd0 && refs_rd_reg != REF_MAX)
                begin
                    refs_we    = 1'b1;
                    refs_waddr = pn_idx;
                    refs_wdata = refs_rd_reg + 16'd1;
                end
            end
            OP_STEAL_END:
            begin
                // The requester's list was empty, so the tail's link is never followed.
                refs_we    = 1'b1;
                refs_waddr = first_reg;
                refs_wdata = 16'd1;
            end
            default:
            begin
                link_we = 1'b0;
            end
        endcase
    end

    // Memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (refs_we)
        begin
            refs_mem[refs_waddr] <= refs_wdata;
        end
        link_rd_reg <= link_mem[link_raddr];
        refs_rd_reg <= refs_mem[refs_raddr];
    end

    // Result word for the finishing commands.
    always_comb
    begin
        res_v   = 1'b1;
        res_st  = ST_OK;
        res_gp  = '0;
        res_rc  = '0;
        res_rel = 1'b0;
        case (cmd.op)
            OP_POP:
            begin
                res_gp = 12'(cur_head);
                res_rc = 16'd1;
            end
            OP_STEAL_END:
            begin
                res_gp = 12'(first_reg);
                res_rc = 16'd1;
            end
            OP_FREE:
            begin
                if (refs_rd_reg == 16'd0)
                begin
                    res_st = ST_UNREF;
                end
                else
                begin
                    res_rc  = refs_rd_reg - 16'd1;
                    res_rel = (refs_rd_reg == 16'd1);
                end
            end
            OP_ADDREF:
            begin
                if (refs_rd_reg == 16'd0)
                begin
                    res_st = ST_UNREF;
                end
                else if (refs_rd_reg == REF_MAX)
                begin
                    res_st = ST_OVF;
                    res_rc = REF_MAX;
                end
                else
                begin
                    res_rc = refs_rd_reg + 16'd1;
                end
            end
            OP_SUP_ALLOC:
            begin
                if (sup_len_reg == '0)
                begin
                    res_st = ST_NONE;
                end
                else
                begin
                    res_gp = 12'(32'(PAGE_COUNT) + 32'(sup_head_reg) * 32'(SUPER_RATIO));
                    res_rc = 16'd1;
                end
            end
            OP_SUP_FREE:
            begin
                if (sup_r == 16'd0)
                begin
                    res_st = ST_UNREF;
                end
                else
                begin
                    res_rc  = sup_r - 16'd1;
                    res_rel = (sup_r == 16'd1);
                end
            end
            OP_SUP_ADDREF:
            begin
                if (sup_r == 16'd0)
                begin
                    res_st = ST_UNREF;
                end
                else if (sup_r == REF_MAX)
                begin
                    res_st = ST_OVF;
                    res_rc = REF_MAX;
                end
                else
                begin
                    res_rc = sup_r + 16'd1;
                end
            end
            OP_BAD:
            begin
                res_st = ST_BAD;
            end
            OP_NOFREE:
            begin
                res_st = ST_NONE;
            end
            default:
            begin
                res_v = 1'b0;
            end
        endcase
    end

    // Request, walk, list and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg      <= '0;
            cpu_reg      <= '0;
            src_reg      <= '0;
            pn_reg       <= '0;
            steal_reg    <= 1'b0;
            scan_i_reg   <= '0;
            n_reg        <= '0;
            k_reg        <= '0;
            first_reg    <= '0;
            second_reg   <= '0;
            clr_cnt_reg  <= '0;
            done_reg     <= 1'b0;
            status_reg   <= ST_OK;
            granted_reg  <= '0;
            refc_reg     <= '0;
            rel_reg      <= 1'b0;
            for (int c = 0; c < CPU_COUNT; c++)
            begin
                head_reg[c] <= (c == 0) ? PW'(PAGE_COUNT - 1) : '0;
                len_reg[c]  <= (c == 0) ? LW'(PAGE_COUNT) : '0;
            end
            for (int s = 0; s < SC1; s++)
            begin
                sup_link_reg[s] <= (s == 0) ? '0 : SW'(s - 1);
                sup_refs_reg[s] <= '0;
            end
            sup_head_reg <= (SUPER_COUNT > 0) ? SW'(SUPER_COUNT - 1) : '0;
            sup_len_reg  <= SLW'(SUPER_COUNT);
        end
        else
        begin
            done_reg <= res_v;
            if (res_v)
            begin
                status_reg  <= res_st;
                granted_reg <= res_gp;
                refc_reg    <= res_rc;
                rel_reg     <= res_rel;
            end
            case (cmd.op)
                OP_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                OP_LATCH:
                begin
                    act_reg   <= action;
                    cpu_reg   <= cpu_mod(cpu);
                    pn_reg    <= page_number;
                    steal_reg <= 1'b0;
                end
                OP_POP:
                begin
                    head_reg[cpu_reg] <= link_rd_reg;
                    len_reg[cpu_reg]  <= cur_len - 1'b1;
                end
                OP_FREE:
                begin
                    if (refs_rd_reg == 16'd1)
                    begin
                        head_reg[cpu_reg] <= pn_idx;
                        len_reg[cpu_reg]  <= cur_len + 1'b1;
                    end
                end
                OP_SCAN_START:
                begin
                    steal_reg  <= 1'b1;
                    src_reg    <= cpu_inc(cpu_reg);
                    scan_i_reg <= IW'(1);
                end
                OP_SCAN_NEXT:
                begin
                    src_reg    <= cpu_inc(src_reg);
                    scan_i_reg <= scan_i_reg + 1'b1;
                end
                OP_STEAL_START:
                begin
                    n_reg     <= n_take;
                    k_reg     <= 6'd1;
                    first_reg <= cur_head;
                end
                OP_WALK:
                begin
                    if (k_reg == 6'd1)
                    begin
                        second_reg <= link_rd_reg;
                    end
                    k_reg <= k_reg + 6'd1;
                end
                OP_STEAL_END:
                begin
                    head_reg[src_reg] <= link_rd_reg;
                    len_reg[src_reg]  <= cur_len - LW'(n_reg);
                    if (n_reg > 6'd1)
                    begin
                        head_reg[cpu_reg] <= second_reg;
                        len_reg[cpu_reg]  <= LW'(n_reg - 6'd1);
                    end
                end
                OP_SUP_ALLOC:
                begin
                    if (sup_len_reg != '0)
                    begin
                        sup_head_reg               <= sup_link_reg[sup_head_reg];
                        sup_len_reg                <= sup_len_reg - 1'b1;
                        sup_refs_reg[sup_head_reg] <= 16'd1;
                    end
                end
                OP_SUP_FREE:
                begin
                    if (sup_r != 16'd0)
                    begin
                        sup_refs_reg[sup_idx] <= sup_r - 16'd1;
                    end
                    if (sup_r == 16'd1)
                    begin
                        sup_link_reg[sup_idx] <= sup_head_reg;
                        sup_head_reg          <= sup_idx;
                        sup_len_reg           <= sup_len_reg + 1'b1;
                    end
                end
                OP_SUP_ADDREF:
                begin
                    if (sup_r != 16'd0 && sup_r != REF_MAX)
                    begin
                        sup_refs_reg[sup_idx] <= sup_r + 16'd1;
                    end
                end
                default:
                begin
                    clr_cnt_reg <= clr_cnt_reg;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_page = granted_reg;
    assign ref_count    = refc_reg;
    assign released     = rel_reg;

endmodule

// ===== rtl/core/rpa_checker.sv =====
`timescale 1ns / 1ps

module rpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic [11:0] granted_page,
    input logic [15:0] ref_count,
    input logic        released
);
    import rpa_pkg::*;

    // An accepted request keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    // A result only follows a busy period.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) && !busy)
        else $error("result word outside a request");

    // Failed allocations, bad addresses and unknown actions carry no page and no count.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_NONE || status == ST_BAD)
            |-> granted_page == 12'd0 && ref_count == 16'd0 && !released)
        else $error("failed request carries data");

    // A release means a successful free that reached zero.
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        done && released |-> status == ST_OK && ref_count == 16'd0)
        else $error("release with live count");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .granted_page (granted_page),
    .ref_count    (ref_count),
    .released     (released)
);
